>>> rtl/gcm_pkg.sv
package gcm_pkg;

  localparam int DENOM_COUNT = 5;
  localparam int AMT_W       = 20;
  localparam int CNT_W       = 10;
  localparam int FACE_W      = 16;
  localparam int Q_W         = CNT_W + 1;
  localparam int IDX_W       = 3;
  localparam int PROD_W      = CNT_W + FACE_W;
  localparam int WIDE_W      = AMT_W + Q_W;

  localparam logic [FACE_W-1:0] FACE_RESET [DENOM_COUNT] =
    '{16'd10, 16'd50, 16'd100, 16'd500, 16'd1000};

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SHORT   = 2'd2
  } status_t;

  typedef struct packed {
    logic [AMT_W-1:0]                   rem;
    logic [DENOM_COUNT-1:0][CNT_W-1:0]  stock;
    logic [DENOM_COUNT-1:0][CNT_W-1:0]  pay;
    logic [FACE_W-1:0]                  short_val;
  } pipe_t;

  typedef struct packed {
    logic [AMT_W-1:0] part;
    logic [Q_W-1:0]   q;
  } div_t;

  // restoring division bits hi down to lo
  function automatic div_t div_bits(input logic [AMT_W-1:0] part,
                                    input logic [Q_W-1:0]   q,
                                    input logic [FACE_W-1:0] face,
                                    input int hi, input int lo);
    div_t r;
    logic [WIDE_W-1:0] sh;
    r.part = part;
    r.q    = q;
    for (int b = Q_W - 1; b >= 0; b--) begin
      if (b <= hi && b >= lo) begin
        sh = WIDE_W'(face) << b;
        if (WIDE_W'(r.part) >= sh) begin
          r.part = r.part - sh[AMT_W-1:0];
          r.q[b] = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/greedy_change_maker.sv
// Greedy change maker with limited supply. Each transaction pays change from
// denomination 4 down to 0 (largest first with the reset face values), limited
// by the pieces on hand, and returns the pieces paid, a status and the face value
// of the last denomination in that order that ran short. A transaction is taken
// in every cycle (busy stays low) and its result appears on the out_ ports,
// marked by out_valid, after five stages per denomination (three of restoring
// division, one of payout multiply, one of remainder subtract) plus the output
// register. The receiver cannot stall, so results must be captured when out_valid is high.
// Write face values only while no transaction is in flight.
module greedy_change_maker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [gcm_pkg::AMT_W-1:0]     in_change_amount,
  input  logic [gcm_pkg::CNT_W-1:0]     in_stock_0,
  input  logic [gcm_pkg::CNT_W-1:0]     in_stock_1,
  input  logic [gcm_pkg::CNT_W-1:0]     in_stock_2,
  input  logic [gcm_pkg::CNT_W-1:0]     in_stock_3,
  input  logic [gcm_pkg::CNT_W-1:0]     in_stock_4,
  output logic                          out_valid,
  output logic [gcm_pkg::CNT_W-1:0]     out_pay_0,
  output logic [gcm_pkg::CNT_W-1:0]     out_pay_1,
  output logic [gcm_pkg::CNT_W-1:0]     out_pay_2,
  output logic [gcm_pkg::CNT_W-1:0]     out_pay_3,
  output logic [gcm_pkg::CNT_W-1:0]     out_pay_4,
  output logic [1:0]                    out_status,
  output logic [gcm_pkg::FACE_W-1:0]    out_short_value,
  input  logic                          cfg_we,
  input  logic [gcm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [gcm_pkg::FACE_W-1:0]    cfg_wdata
);
  import gcm_pkg::*;

  logic [FACE_W-1:0] face_r [DENOM_COUNT];
  logic              vld   [DENOM_COUNT+1];
  pipe_t             pipe  [DENOM_COUNT+1];

  logic                              out_valid_r;
  logic [DENOM_COUNT-1:0][CNT_W-1:0] pay_r, pay_nxt;
  status_t                           status_r, status_nxt;
  logic [FACE_W-1:0]                 short_r, short_nxt;
  logic                              invalid;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DENOM_COUNT; k++) begin
        face_r[k] <= FACE_RESET[k];
      end
    end else if (cfg_we && (32'(cfg_index) < DENOM_COUNT)) begin
      face_r[cfg_index] <= cfg_wdata;
    end
  end

  always_comb begin
    vld[0]            = start;
    pipe[0].rem       = in_change_amount;
    pipe[0].stock     = {in_stock_4, in_stock_3, in_stock_2, in_stock_1, in_stock_0};
    pipe[0].pay       = '0;
    pipe[0].short_val = '0;
  end

  for (genvar g = 0; g < DENOM_COUNT; g++) begin : g_denom
    gcm_denom #(.IDX(DENOM_COUNT - 1 - g)) u_denom (
      .clk      (clk),
      .rst_n    (rst_n),
      .face     (face_r[DENOM_COUNT-1-g]),
      .in_vld   (vld[g]),
      .in_pipe  (pipe[g]),
      .out_vld  (vld[g+1]),
      .out_pipe (pipe[g+1])
    );
  end

  always_comb begin
    invalid = 1'b0;
    for (int k = 0; k < DENOM_COUNT; k++) begin
      if (face_r[k] == '0) invalid = 1'b1;
    end
    pay_nxt    = pipe[DENOM_COUNT].pay;
    short_nxt  = '0;
    status_nxt = ST_OK;
    if (invalid) begin
      pay_nxt    = '0;
      status_nxt = ST_INVALID;
    end else if (pipe[DENOM_COUNT].rem != '0) begin
      status_nxt = ST_SHORT;
      short_nxt  = pipe[DENOM_COUNT].short_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld[DENOM_COUNT];
    end
    pay_r    <= pay_nxt;
    status_r <= status_nxt;
    short_r  <= short_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pay_0       = pay_r[0];
  assign out_pay_1       = pay_r[1];
  assign out_pay_2       = pay_r[2];
  assign out_pay_3       = pay_r[3];
  assign out_pay_4       = pay_r[4];
  assign out_status      = status_r;
  assign out_short_value = short_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##26 out_valid) else $error("result missing after fixed latency");

  a_ok_short: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |-> out_short_value == '0)
    else $error("short value set on ok status");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_INVALID) |->
      (out_pay_0 == '0 && out_pay_4 == '0 && out_short_value == '0))
    else $error("nonzero payout on invalid denomination");

endmodule

>>> rtl/gcm_denom.sv
module gcm_denom #(
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [gcm_pkg::FACE_W-1:0] face,
  input  logic                   in_vld,
  input  gcm_pkg::pipe_t         in_pipe,
  output logic                   out_vld,
  output gcm_pkg::pipe_t         out_pipe
);
  import gcm_pkg::*;

  logic              a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r;
  pipe_t             a_pipe_r, b_pipe_r, c_pipe_r, d_pipe_r, e_pipe_r;
  logic              a_sat_r, b_sat_r, c_sat_r;
  div_t              a_div_r, b_div_r, c_div_r;
  logic [PROD_W-1:0] d_prod_r;

  div_t              a_div_nxt, b_div_nxt, c_div_nxt;
  logic              a_sat_nxt, need_gt;
  logic [CNT_W-1:0]  take, avail;
  pipe_t             d_pipe_nxt, e_pipe_nxt;

  always_comb begin
    a_sat_nxt = WIDE_W'(in_pipe.rem) >= (WIDE_W'(face) << Q_W);
    a_div_nxt = div_bits(in_pipe.rem, '0, face, Q_W - 1, 7);
    b_div_nxt = div_bits(a_div_r.part, a_div_r.q, face, 6, 3);
    c_div_nxt = div_bits(b_div_r.part, b_div_r.q, face, 2, 0);
  end

  always_comb begin
    avail      = c_pipe_r.stock[IDX];
    need_gt    = c_sat_r || (c_div_r.q > Q_W'(avail));
    take       = need_gt ? avail : c_div_r.q[CNT_W-1:0];
    d_pipe_nxt = c_pipe_r;
    d_pipe_nxt.pay[IDX] = take;
    if (need_gt) begin
      d_pipe_nxt.short_val = face;
    end
    e_pipe_nxt     = d_pipe_r;
    e_pipe_nxt.rem = d_pipe_r.rem - d_prod_r[AMT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
    end
    a_pipe_r <= in_pipe;
    a_sat_r  <= a_sat_nxt;
    a_div_r  <= a_div_nxt;
    b_pipe_r <= a_pipe_r;
    b_sat_r  <= a_sat_r;
    b_div_r  <= b_div_nxt;
    c_pipe_r <= b_pipe_r;
    c_sat_r  <= b_sat_r;
    c_div_r  <= c_div_nxt;
    d_pipe_r <= d_pipe_nxt;
    d_prod_r <= PROD_W'(take) * PROD_W'(face);
    e_pipe_r <= e_pipe_nxt;
  end

  assign out_vld  = e_vld_r;
  assign out_pipe = e_pipe_r;

endmodule

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gcm_pkg::*;

  typedef struct {
    logic [CNT_W-1:0]  pay [DENOM_COUNT];
    status_t           status;
    logic [FACE_W-1:0] short_value;
  } payout_t;

  class payout_board;
    logic [FACE_W-1:0] face [DENOM_COUNT];
    payout_t pending [$];
    int errors;

    function new();
      for (int k = 0; k < DENOM_COUNT; k++) face[k] = FACE_RESET[k];
      errors = 0;
    endfunction

    function void set_face(int idx, logic [FACE_W-1:0] v);
      if (idx < DENOM_COUNT) face[idx] = v;
    endfunction

    function void note_input(logic [AMT_W-1:0] amt, logic [CNT_W-1:0] stock [DENOM_COUNT]);
      payout_t p;
      logic [31:0] rem, need, take;
      bit bad;
      rem = 32'(amt);
      bad = 0;
      p.short_value = '0;
      for (int k = 0; k < DENOM_COUNT; k++) begin
        p.pay[k] = '0;
        if (face[k] == 0) bad = 1;
      end
      if (bad) begin
        p.status = ST_INVALID;
      end else begin
        for (int k = DENOM_COUNT - 1; k >= 0; k--) begin
          need = rem / face[k];
          take = need;
          if (need > stock[k]) begin
            p.short_value = face[k];
            take = 32'(stock[k]);
          end
          p.pay[k] = take[CNT_W-1:0];
          rem = rem - take * face[k];
        end
        if (rem > 0) p.status = ST_SHORT;
        else begin
          p.status = ST_OK;
          p.short_value = '0;
        end
      end
      pending.push_back(p);
    endfunction

    function void check_result(logic [CNT_W-1:0] pay [DENOM_COUNT], logic [1:0] st,
                               logic [FACE_W-1:0] sv);
      payout_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int k = 0; k < DENOM_COUNT; k++)
        if (pay[k] !== e.pay[k]) begin
          $error("pay_%0d expected %0d actual %0d", k, e.pay[k], pay[k]);
          errors++;
        end
      if (st !== e.status) begin
        $error("status expected %0d actual %0d", e.status, st);
        errors++;
      end
      if (sv !== e.short_value) begin
        $error("short_value expected %0d actual %0d", e.short_value, sv);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 26;

  logic clk, rst_n, start, busy, out_valid, cfg_we;
  logic [AMT_W-1:0] in_change_amount;
  logic [CNT_W-1:0] in_stock [DENOM_COUNT];
  logic [CNT_W-1:0] out_pay [DENOM_COUNT];
  logic [1:0] out_status;
  logic [FACE_W-1:0] out_short_value, cfg_wdata;
  logic [IDX_W-1:0] cfg_index;
  payout_board board;
  int cycles;

  greedy_change_maker DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_change_amount(in_change_amount),
    .in_stock_0(in_stock[0]), .in_stock_1(in_stock[1]), .in_stock_2(in_stock[2]),
    .in_stock_3(in_stock[3]), .in_stock_4(in_stock[4]),
    .out_valid(out_valid),
    .out_pay_0(out_pay[0]), .out_pay_1(out_pay[1]), .out_pay_2(out_pay[2]),
    .out_pay_3(out_pay[3]), .out_pay_4(out_pay[4]),
    .out_status(out_status), .out_short_value(out_short_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    board = new();
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("** greedy_change_maker: FAILED **");
      $finish;
    end
    if (rst_n && out_valid) board.check_result(out_pay, out_status, out_short_value);
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_change(logic [AMT_W-1:0] amt, logic [CNT_W-1:0] stk [DENOM_COUNT]);
    in_change_amount <= amt;
    for (int k = 0; k < DENOM_COUNT; k++) in_stock[k] <= stk[k];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_input(amt, stk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_face(int idx, logic [FACE_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx[IDX_W-1:0];
    cfg_wdata <= v;
    @(posedge clk);
    board.set_face(idx, v);
  endtask

  task automatic random_item(int mode);
    logic [CNT_W-1:0] stk [DENOM_COUNT];
    logic [AMT_W-1:0] amt;
    for (int k = 0; k < DENOM_COUNT; k++)
      stk[k] = (mode == 0) ? CNT_W'($urandom_range(0, 1023)) : CNT_W'($urandom_range(0, 12));
    amt = (mode == 0) ? AMT_W'($urandom_range(0, 1048575)) : AMT_W'($urandom_range(0, 30000));
    send_change(amt, stk);
    idle_gap();
  endtask

  initial begin
    logic [CNT_W-1:0] stk [DENOM_COUNT];
    logic [FACE_W-1:0] fv [DENOM_COUNT];
    rst_n = 0; start = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_change_amount = '0;
    for (int k = 0; k < DENOM_COUNT; k++) in_stock[k] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stk[k]) stk[k] = '1;
    send_change('0, stk);
    send_change('1, stk);
    send_change(20'd1885, stk);
    send_change(20'd5, stk);
    foreach (stk[k]) stk[k] = '0;
    send_change(20'd1000, stk);
    send_change('1, stk);
    send_change('0, stk);
    stk[4] = 1; stk[3] = 0; stk[2] = 3; stk[1] = 1; stk[0] = 2;
    send_change(20'd1890, stk);
    send_change(20'd1375, stk);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: fv = '{16'd1, 16'd2, 16'd5, 16'd10, 16'd20};
        1: fv = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        2: fv = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
        3: fv = '{16'd0, 16'd50, 16'd100, 16'd500, 16'd1000};
        4: fv = '{16'd1000, 16'd500, 16'd100, 16'd50, 16'd10};
        5: fv = '{16'd7, 16'd13, 16'd0, 16'd300, 16'd4000};
        6: foreach (fv[k]) fv[k] = FACE_W'($urandom_range(1, 65535));
        default: fv = '{16'd1, 16'd5, 16'd25, 16'd100, 16'd2000};
      endcase
      foreach (fv[k]) write_face(k, fv[k]);
      write_face(5 + phase % 3, FACE_W'($urandom));
      cfg_we <= 1'b0;
      for (int i = 0; i < 135; i++) random_item($urandom_range(0, 1));
      if (phase == 2) begin
        foreach (stk[k]) stk[k] = '1;
        send_change('1, stk);
        send_change(20'd5115, stk);
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("** greedy_change_maker: PASSED **");
    end else begin
      $display("** greedy_change_maker: FAILED **");
    end
    $finish;
  end
endmodule
